### design/plst_pkg.sv
`default_nettype none
package plst_pkg;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [7:0]         position;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] word_out;
		logic [7:0]         count;
	} out_item_t;

	typedef struct packed {
		logic               upd;
		mode_t              mode;
		logic signed [31:0] value;
	} cell_ctl_t;

	localparam int GRP_SIZE = 16;

endpackage
`default_nettype wire

### design/plst_cell.sv
`default_nettype none
module plst_cell #(
	parameter int AW = 7,
	parameter logic [AW-1:0] IDX = '0
) (
	input  wire logic                      clk,
	input  wire plst_pkg::cell_ctl_t       ctl,
	input  wire logic [AW-1:0]             tgt,
	input  wire logic signed [31:0]        left,
	input  wire logic signed [31:0]        right,
	output logic signed [31:0]             word,
	output logic signed [31:0]             rd
);
	import plst_pkg::*;

	logic signed [31:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			case (ctl.mode)
				MODE_APPEND: begin
					if (IDX == tgt) begin
						word_q <= ctl.value;
					end
				end
				MODE_INSERT: begin
					if (IDX == tgt) begin
						word_q <= ctl.value;
					end else if (IDX > tgt) begin
						word_q <= left;
					end
				end
				MODE_DELETE: begin
					if (IDX >= tgt) begin
						word_q <= right;
					end
				end
				MODE_READ: begin
					word_q <= word_q;
				end
				default: begin
					word_q <= word_q;
				end
			endcase
		end
	end

	assign word = word_q;
	assign rd   = (IDX == tgt) ? word_q : '0;

endmodule
`default_nettype wire

### design/positional_list_store_core.sv
// Ordered list of up to CAPACITY signed 32-bit words, held in a row of cells.
// Input channel in_valid/in_ready/in_data carries one request: append, insert
// at a 1-based position, delete at a position, or read at a position.
// Output channel out_valid/out_ready/out_data carries one result per request:
// a status, the deleted or read word (zero otherwise) and the new length.
// A request is registered when taken; the addressed word is gathered through a
// two-level OR tree over groups of sixteen cells whose group level is
// registered, and the cells shift in the cycle the result is loaded into the
// output register. A new request is not taken until the previous result has
// been loaded into the output register.
// The input is accepted again as soon as the result sits in the output
// register, even if the receiver has not yet taken it. When the receiver
// stalls with a result held, a second request waits in the tree stage and
// the input stays not ready until the output register frees up.
// Reset empties the list and clears all valid flags; cell contents are left
// as they are and are never read before they are written.
`default_nettype none
module positional_list_store_core #(
	parameter int CAPACITY = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire plst_pkg::in_item_t    in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output plst_pkg::out_item_t        out_data
);
	import plst_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = ((FW > 8) ? FW : 8) + 1;
	localparam int NG = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	logic               v1_q;
	logic               v2_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic [FW-1:0]      fill_q;

	mode_t              mode_s1;
	status_t            status_s1;
	logic [AW-1:0]      tgt_s1;
	logic signed [31:0] value_s1;
	logic               upd_s1;
	logic               need_word_s1;

	logic signed [31:0] grp_s2 [NG];

	logic               acc_in;
	logic               adv2;
	logic [CW-1:0]      pos_w;
	logic [CW-1:0]      fill_w;
	logic [CW-1:0]      pos_m1;
	status_t            status_d;
	logic [AW-1:0]      tgt_d;
	logic [FW-1:0]      fill_nxt;
	logic signed [31:0] word_sel;

	logic signed [31:0] cell_word [CAPACITY];
	logic signed [31:0] rd_w [NG*GRP_SIZE];
	cell_ctl_t          ctl;

	assign in_ready  = !v1_q && !v2_q;
	assign acc_in    = in_valid && in_ready;
	assign adv2      = v2_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign pos_w  = CW'(in_data.position);
	assign fill_w = CW'(fill_q);
	assign pos_m1 = pos_w - CW'(1);

	always_comb begin
		status_d = ST_DONE;
		case (in_data.mode)
			MODE_APPEND: begin
				if (fill_w >= CW'(CAPACITY)) begin
					status_d = ST_FULL;
				end
			end
			MODE_INSERT: begin
				if (pos_w == '0 || pos_w > fill_w + CW'(1)) begin
					status_d = ST_BADPOS;
				end else if (fill_w >= CW'(CAPACITY)) begin
					status_d = ST_FULL;
				end
			end
			MODE_DELETE, MODE_READ: begin
				if (pos_w == '0 || pos_w > fill_w) begin
					status_d = ST_BADPOS;
				end
			end
			default: begin
				status_d = ST_BADPOS;
			end
		endcase
	end

	assign tgt_d = (in_data.mode == MODE_APPEND) ? AW'(fill_q) : AW'(pos_m1);

	always_ff @(posedge clk) begin
		if (acc_in) begin
			mode_s1      <= in_data.mode;
			status_s1    <= status_d;
			tgt_s1       <= tgt_d;
			value_s1     <= in_data.value;
			upd_s1       <= (status_d == ST_DONE) && (in_data.mode != MODE_READ);
			need_word_s1 <= (status_d == ST_DONE) &&
				(in_data.mode == MODE_DELETE || in_data.mode == MODE_READ);
		end
	end

	assign ctl.upd   = adv2 && upd_s1;
	assign ctl.mode  = mode_s1;
	assign ctl.value = value_s1;

	for (genvar i = 0; i < NG * GRP_SIZE; i++) begin : g_cell
		if (i < CAPACITY) begin : g_real
			logic signed [31:0] left_w;
			logic signed [31:0] right_w;
			if (i == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = cell_word[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = cell_word[i+1];
			end
			plst_cell #(
				.AW  (AW),
				.IDX (AW'(i))
			) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.tgt   (tgt_s1),
				.left  (left_w),
				.right (right_w),
				.word  (cell_word[i]),
				.rd    (rd_w[i])
			);
		end else begin : g_pad
			assign rd_w[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			logic signed [31:0] acc;
			acc = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				acc = acc | rd_w[g*GRP_SIZE + j];
			end
			grp_s2[g] <= acc;
		end
	end

	always_comb begin
		word_sel = '0;
		for (int g = 0; g < NG; g++) begin
			word_sel = word_sel | grp_s2[g];
		end
	end

	always_comb begin
		fill_nxt = fill_q;
		if (upd_s1) begin
			if (mode_s1 == MODE_DELETE) begin
				fill_nxt = fill_q - FW'(1);
			end else begin
				fill_nxt = fill_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_q.status   <= status_s1;
			out_q.word_out <= need_word_s1 ? word_sel : '0;
			out_q.count    <= 8'(fill_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
			fill_q      <= '0;
		end else begin
			v1_q <= acc_in;
			if (v1_q) begin
				v2_q <= 1'b1;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
				fill_q      <= fill_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
